[src/fbat_pkg.sv]
`timescale 1ns / 1ps

package fbat_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W         = (CNT_W > 4) ? CNT_W : 4;

  // Operation codes
  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SET    = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // One stored band
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic [3:0]  ch;
    logic        en;
  } entry_t;

endpackage

[src/frequency_band_antenna_table_unit.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Handshake             | Payload
// in_*     | input     | in_valid / in_ready   | opcode, index, frequency, entry fields
// out_*    | output    | out_valid / out_ready | channel, match, status, read fields, count
//
// One item at a time. Add, set and unused codes go from S_EXEC straight to S_RESP;
// read passes S_RDWAIT between them. Lookup and remove walk the table through
// the single read port of the band RAM, one entry a cycle.
// Reset (rst_n low, synchronous) empties the table; RAM contents are not cleared.
// A finished result waits in the output register; the next item is taken meanwhile
// and only the final step waits on out_ready.

module frequency_band_antenna_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_entry_index,
  input  logic [31:0] in_freq_hz,
  input  logic [31:0] in_entry_min_freq,
  input  logic [31:0] in_entry_max_freq,
  input  logic [3:0]  in_entry_channel,
  input  logic        in_entry_enabled,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_antenna_channel,
  output logic        out_match_found,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_min_freq,
  output logic [31:0] out_read_max_freq,
  output logic [3:0]  out_read_channel,
  output logic        out_read_enabled,
  output logic [4:0]  out_band_count
);

  localparam int AW = fbat_pkg::ADDR_W;
  localparam int CW = fbat_pkg::CNT_W;
  localparam int MW = fbat_pkg::CMP_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]       state_r;
  logic [2:0]       op_r;
  logic [3:0]       idx_r;
  logic [31:0]      freq_r;
  logic [31:0]      lo_r;
  logic [31:0]      hi_r;
  logic [3:0]       ch_r;
  logic             en_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    ptr_r;
  logic             chk_r;

  logic [3:0]       res_ch_r;
  logic             res_match_r;
  logic [1:0]       res_status_r;
  fbat_pkg::entry_t res_rd_r;

  logic             out_valid_r;
  logic [3:0]       out_ch_r;
  logic             out_match_r;
  logic [1:0]       out_status_r;
  fbat_pkg::entry_t out_rd_r;
  logic [4:0]       out_count_r;

  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  fbat_pkg::entry_t ram_wr_data;
  logic [AW-1:0]    ram_rd_addr;
  fbat_pkg::entry_t ram_rd_data;

  logic             idx_ok;
  logic             not_full;
  logic             ptr_live;
  logic [CW-1:0]    ptr_m2;
  logic             hit;

  assign in_ready = (state_r == S_IDLE);

  assign idx_ok   = MW'(idx_r) < MW'(count_r);
  assign not_full = count_r < CW'(fbat_pkg::TABLE_ENTRIES);
  assign ptr_live = ptr_r < count_r;
  assign ptr_m2   = ptr_r - CW'(2);
  assign hit      = chk_r && ram_rd_data.en &&
                    (freq_r >= ram_rd_data.lo) && (freq_r <= ram_rd_data.hi);

  // RAM port steering
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = count_r[AW-1:0];
    ram_wr_data = '{lo: lo_r, hi: hi_r, ch: ch_r, en: en_r};
    ram_rd_addr = ptr_r[AW-1:0];
    case (state_r)
      S_EXEC: begin
        ram_rd_addr = AW'(idx_r);
        if (op_r == fbat_pkg::OP_ADD) begin
          ram_wr_en = not_full;
        end else if (op_r == fbat_pkg::OP_SET) begin
          ram_wr_en   = idx_ok;
          ram_wr_addr = AW'(idx_r);
        end
      end
      S_SHIFT: begin
        // move entry ptr-1 down to ptr-2
        ram_wr_en   = chk_r;
        ram_wr_addr = ptr_m2[AW-1:0];
        ram_wr_data = ram_rd_data;
      end
      default: begin
      end
    endcase
  end

  fbat_ram #(
    .WIDTH($bits(fbat_pkg::entry_t)),
    .DEPTH(fbat_pkg::TABLE_ENTRIES)
  ) u_band_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Sequencer, table count and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_RESP a new result takes the place of the one leaving
      if (out_valid_r && out_ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            idx_r   <= in_entry_index;
            freq_r  <= in_freq_hz;
            lo_r    <= in_entry_min_freq;
            hi_r    <= in_entry_max_freq;
            ch_r    <= in_entry_channel;
            en_r    <= in_entry_enabled;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_ch_r     <= '0;
          res_match_r  <= 1'b0;
          res_status_r <= fbat_pkg::ST_OK;
          res_rd_r     <= '0;
          chk_r        <= 1'b0;
          state_r      <= S_RESP;
          case (op_r)
            fbat_pkg::OP_LOOKUP: begin
              ptr_r   <= '0;
              state_r <= S_LOOK;
            end
            fbat_pkg::OP_ADD: begin
              if (not_full) begin
                count_r <= count_r + CW'(1);
              end else begin
                res_status_r <= fbat_pkg::ST_FULL;
              end
            end
            fbat_pkg::OP_SET: begin
              if (!idx_ok) begin
                res_status_r <= fbat_pkg::ST_RANGE;
              end
            end
            fbat_pkg::OP_REMOVE: begin
              if (idx_ok) begin
                ptr_r   <= CW'(idx_r) + CW'(1);
                state_r <= S_SHIFT;
              end else begin
                res_status_r <= fbat_pkg::ST_RANGE;
              end
            end
            fbat_pkg::OP_READ: begin
              if (idx_ok) begin
                state_r <= S_RDWAIT;
              end else begin
                res_status_r <= fbat_pkg::ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
        S_LOOK: begin
          // check the entry read last cycle, issue the next one
          if (hit) begin
            res_ch_r    <= ram_rd_data.ch;
            res_match_r <= 1'b1;
            chk_r       <= 1'b0;
            state_r     <= S_RESP;
          end else if (ptr_live) begin
            ptr_r <= ptr_r + CW'(1);
            chk_r <= 1'b1;
          end else begin
            chk_r   <= 1'b0;
            state_r <= S_RESP;
          end
        end
        S_SHIFT: begin
          if (ptr_live) begin
            ptr_r <= ptr_r + CW'(1);
            chk_r <= 1'b1;
          end else begin
            count_r <= count_r - CW'(1);
            chk_r   <= 1'b0;
            state_r <= S_RESP;
          end
        end
        S_RDWAIT: begin
          res_rd_r <= ram_rd_data;
          state_r  <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_ch_r     <= res_ch_r;
            out_match_r  <= res_match_r;
            out_status_r <= res_status_r;
            out_rd_r     <= res_rd_r;
            out_count_r  <= 5'(count_r);
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_antenna_channel = out_ch_r;
  assign out_match_found     = out_match_r;
  assign out_status          = out_status_r;
  assign out_read_min_freq   = out_rd_r.lo;
  assign out_read_max_freq   = out_rd_r.hi;
  assign out_read_channel    = out_rd_r.ch;
  assign out_read_enabled    = out_rd_r.en;
  assign out_band_count      = out_count_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(fbat_pkg::TABLE_ENTRIES))
    else $error("entry count above table size");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (CW'(ram_wr_addr) <= count_r))
    else $error("RAM write beyond the filled part of the table");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == fbat_pkg::ST_FULL) |->
      (out_band_count == 5'(fbat_pkg::TABLE_ENTRIES)))
    else $error("table full reported with table not full");

endmodule

[src/fbat_ram.sv]
`timescale 1ns / 1ps

module fbat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
